// ===== src/mm3_pkg.sv =====
// Package for the MurmurHash3 x86_32 stream hash unit.
// Holds the hash constants, the result struct and small bit-level helpers.
// No dependencies.
`default_nettype none

package mm3_pkg;

  localparam logic [31:0] C1    = 32'hcc9e2d51;
  localparam logic [31:0] C2    = 32'h1b873593;
  localparam logic [31:0] N_ADD = 32'he6546b64;
  localparam logic [31:0] F1    = 32'h85ebca6b;
  localparam logic [31:0] F2    = 32'hc2b2ae35;

  localparam logic [2:0] FULL_BYTES = 3'd4;

  typedef struct packed {
    logic        valid;
    logic [31:0] value;
  } mm3_res_t;

  function automatic logic [31:0] rotl15(input logic [31:0] x);
    return {x[16:0], x[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] x);
    return {x[18:0], x[31:19]};
  endfunction

  // Keeps only the valid low bytes of a partial last word.
  function automatic logic [31:0] tail_mask(input logic [2:0] n);
    logic [31:0] m;
    case (n)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== src/mm3_stream_if.sv =====
// Valid/ready channel interfaces for the hash unit: message words in, hash out.
// Depends on nothing.
`default_nettype none

interface mm3_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_data;
  logic [2:0]  byte_count;
  logic        last_word;

  modport source(output valid, word_data, byte_count, last_word, input ready);
  modport sink(input valid, word_data, byte_count, last_word, output ready);
endinterface

interface mm3_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source(output valid, hash_value, input ready);
  modport sink(input valid, hash_value, output ready);
endinterface

`default_nettype wire

// ===== src/mm3_mul.sv =====
// Shared 32x32 multiplier keeping the low 32 bits, with a registered product.
// Depends on nothing.
`default_nettype none

module mm3_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] p
);

  logic [31:0] full;

  // Only the low half of the product is ever needed.
  assign full = a * b;

  always_ff @(posedge clk) begin
    p <= full;
  end

endmodule

`default_nettype wire

// ===== src/mm3_engine.sv =====
// Sequencer and state registers of the hash unit; drives the shared multiplier.
// Depends on mm3_pkg, mm3_word_if and mm3_mul.
`default_nettype none

module mm3_engine
  import mm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] seed,
  mm3_word_if.sink         words,
  input  wire logic        res_take,
  output mm3_res_t         res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_K1   = 3'd1;
  localparam logic [2:0] S_K2   = 3'd2;
  localparam logic [2:0] S_MIX  = 3'd3;
  localparam logic [2:0] S_FIN1 = 3'd4;
  localparam logic [2:0] S_FIN2 = 3'd5;
  localparam logic [2:0] S_FIN3 = 3'd6;

  logic [2:0]  state, state_next;
  logic        mid;
  logic [31:0] h;
  logic [31:0] len;
  logic [31:0] k;
  logic [2:0]  n_q;
  logic        last_q;

  logic [31:0] mul_a, mul_b, p;
  logic [2:0]  n_sat;
  logic        accept;
  logic [31:0] hx, hr, h_blk, hl, fin_t;
  logic        full_blk;

  mm3_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  assign words.ready = (state == S_IDLE);
  assign accept      = words.valid && words.ready;

  // Byte count is honored on the last word only; above four it saturates.
  always_comb begin
    if (!words.last_word || words.byte_count > FULL_BYTES) begin
      n_sat = FULL_BYTES;
    end else begin
      n_sat = words.byte_count;
    end
  end

  assign full_blk = (n_q == FULL_BYTES);
  assign hx       = h ^ p;
  assign hr       = rotl13(hx);
  assign h_blk    = hr + {hr[29:0], 2'b00} + N_ADD;
  assign hl       = h ^ len;
  assign fin_t    = hl ^ (hl >> 16);

  always_comb begin
    case (state)
      S_K1: begin
        mul_a = k;
        mul_b = C1;
      end
      S_K2: begin
        mul_a = rotl15(p);
        mul_b = C2;
      end
      S_FIN1: begin
        mul_a = fin_t;
        mul_b = F1;
      end
      S_FIN2: begin
        mul_a = p ^ (p >> 13);
        mul_b = F2;
      end
      S_FIN3: begin
        // Multiplying by one keeps the final product while the hash waits.
        mul_a = p;
        mul_b = 32'd1;
      end
      default: begin
        mul_a = k;
        mul_b = C1;
      end
    endcase
  end

  assign res.valid = (state == S_FIN3);
  assign res.value = p ^ (p >> 16);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (words.last_word && n_sat == 3'd0) begin
            state_next = S_FIN1;
          end else begin
            state_next = S_K1;
          end
        end
      end
      S_K1:   state_next = S_K2;
      S_K2:   state_next = S_MIX;
      S_MIX:  state_next = last_q ? S_FIN1 : S_IDLE;
      S_FIN1: state_next = S_FIN2;
      S_FIN2: state_next = S_FIN3;
      S_FIN3: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mid   <= 1'b0;
      h     <= '0;
      len   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        mid <= 1'b1;
        // The seed is taken only when a new message begins.
        if (!mid) begin
          h   <= seed;
          len <= '0;
        end
      end
      if (state == S_MIX) begin
        h   <= full_blk ? h_blk : hx;
        len <= len + 32'(n_q);
      end
      if (state == S_FIN3 && res_take) begin
        mid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      k      <= words.word_data & tail_mask(n_sat);
      n_q    <= n_sat;
      last_q <= words.last_word;
    end
  end

endmodule

`default_nettype wire

// ===== src/murmur3_32_stream_hash_unit.sv =====
// MurmurHash3 x86_32 over a stream of little-endian words, one shared multiplier.
// A word passes through the states K1, K2 and MIX before the next word can be taken;
// the last word then runs the finalizer states FIN1, FIN2 and FIN3 (an empty last word
// goes straight to FIN1), all paced by the single shared 32x32 multiplier.
// The result register lets the next message start while the hash waits.
// Synchronous active-high reset clears the sequencer, message state and seed to 0.
`default_nettype none

module murmur3_32_stream_hash_unit
  import mm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  mm3_word_if.sink         words,
  mm3_hash_if.source       hash
);

  logic [31:0] seed;
  logic        out_valid;
  logic [31:0] out_value;
  logic        res_take;
  mm3_res_t    res;

  assign res_take = !out_valid || hash.ready;

  mm3_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .seed     (seed),
    .words    (words),
    .res_take (res_take),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed <= cfg_wdata;
      end
      if (res.valid && res_take) begin
        out_valid <= 1'b1;
      end else if (hash.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_take) begin
      out_value <= res.value;
    end
  end

  assign hash.valid      = out_valid;
  assign hash.hash_value = out_value;

endmodule

`default_nettype wire

// ===== src/mm3_checker.sv =====
// Port-level checks for the hash unit, attached to the top level by bind.
// Depends on murmur3_32_stream_hash_unit and its interfaces.
`default_nettype none

module mm3_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [2:0]  in_count,
  input wire logic        in_last,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value
);

  logic in_xfer;

  assign in_xfer = in_valid && in_ready;

  // Every word keeps the shared multiplier busy, so input ready stays low after it.
  a_word_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input ready too soon after a word transfer");

  // A last word with data runs the block mix and the finalizer.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_last && in_count != 3'd0 |=>
      !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input ready too soon after a last word");

  // No hash is offered before a last word could have been finalized.
  a_no_early_hash: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !$rose(out_valid) ##1 !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("hash appeared too soon after a word transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("stalled hash changed or dropped");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("hash valid after reset");

endmodule

bind murmur3_32_stream_hash_unit mm3_checker u_mm3_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (words.valid),
  .in_ready  (words.ready),
  .in_count  (words.byte_count),
  .in_last   (words.last_word),
  .out_valid (hash.valid),
  .out_ready (hash.ready),
  .out_value (hash.hash_value)
);

`default_nettype wire
